FILE: rtl/cfb_pkg.sv
// cfb_pkg: shared types and constants for the command frame builder
`timescale 1ns / 1ps

package cfb_pkg;

  // frame sync bytes
  localparam logic [7:0] SYNC_FIRST  = 8'h49;
  localparam logic [7:0] SYNC_SECOND = 8'h37;

  // input transaction modes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // byte position within a frame (header, payload, checksum)
  localparam int         POS_W        = 4;
  localparam logic [3:0] POS_SYNC1    = 4'd0;
  localparam logic [3:0] POS_SYNC2    = 4'd1;
  localparam logic [3:0] POS_SEQ_LO   = 4'd2;
  localparam logic [3:0] POS_SEQ_HI   = 4'd3;
  localparam logic [3:0] POS_CMD      = 4'd4;
  localparam logic [3:0] POS_STAT     = 4'd5;
  localparam logic [3:0] POS_LEN_LO   = 4'd6;
  localparam logic [3:0] POS_LEN_HI   = 4'd7;
  localparam logic [3:0] POS_SUM_LO   = 4'd8;
  localparam logic [3:0] POS_SUM_HI   = 4'd9;
  localparam logic [3:0] POS_DATA     = 4'd10;

  // last byte index of each burst shape
  localparam logic [3:0] LAST_HDR     = 4'd7;
  localparam logic [3:0] LAST_HDR_SUM = 4'd9;
  localparam logic [3:0] LAST_PAY     = 4'd0;
  localparam logic [3:0] LAST_PAY_SUM = 4'd2;

  // everything needed to emit the bytes caused by one transaction
  typedef struct packed {
    logic        hdr;       // 1: header burst, 0: one payload byte
    logic        with_sum;  // checksum bytes follow
    logic [15:0] seq;
    logic [7:0]  cmd;
    logic [7:0]  stat;
    logic [7:0]  len;
    logic [7:0]  data;
    logic [15:0] sum;
  } burst_t;

endpackage

FILE: rtl/cfb_emitter.sv
// cfb_emitter: holds one burst and streams its bytes through an output register
`timescale 1ns / 1ps

module cfb_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  cfb_pkg::burst_t burst_in,
  output logic            free,
  output logic            valid,
  input  logic            stall,
  output logic [7:0]      frame_byte,
  output logic            frame_end
);
  import cfb_pkg::*;

  burst_t           burst;
  logic             burst_valid;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] last_idx;
  logic [POS_W-1:0] pos;
  logic [7:0]       sel_byte;
  logic             out_load;
  logic             burst_last;

  // last index of the held burst
  always_comb begin
    if (burst.hdr) begin
      last_idx = burst.with_sum ? LAST_HDR_SUM : LAST_HDR;
    end else begin
      last_idx = burst.with_sum ? LAST_PAY_SUM : LAST_PAY;
    end
  end

  // map burst index to frame position
  always_comb begin
    if (burst.hdr) begin
      pos = idx;
    end else if (idx == '0) begin
      pos = POS_DATA;
    end else begin
      pos = idx + (POS_SUM_LO - 4'd1);
    end
  end

  // byte select
  always_comb begin
    case (pos)
      POS_SYNC1:  sel_byte = SYNC_FIRST;
      POS_SYNC2:  sel_byte = SYNC_SECOND;
      POS_SEQ_LO: sel_byte = burst.seq[7:0];
      POS_SEQ_HI: sel_byte = burst.seq[15:8];
      POS_CMD:    sel_byte = burst.cmd;
      POS_STAT:   sel_byte = burst.stat;
      POS_LEN_LO: sel_byte = burst.len;
      POS_LEN_HI: sel_byte = 8'h00;
      POS_SUM_LO: sel_byte = burst.sum[7:0];
      POS_SUM_HI: sel_byte = burst.sum[15:8];
      POS_DATA:   sel_byte = burst.data;
      default:    sel_byte = 8'h00;
    endcase
  end

  assign out_load   = !valid || !stall;
  assign burst_last = (idx == last_idx);
  assign free       = !burst_valid || (out_load && burst_last);

  // burst register and index
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      burst_valid <= 1'b1;
      idx         <= '0;
    end else if (burst_valid && out_load) begin
      if (burst_last) begin
        burst_valid <= 1'b0;
        idx         <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_load) begin
      valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && burst_valid) begin
      frame_byte <= sel_byte;
      frame_end  <= (pos == POS_SUM_HI);
    end
  end

endmodule

FILE: rtl/command_frame_builder.sv
// command_frame_builder: top level, frame state and checksum, byte emitter
`timescale 1ns / 1ps
//
// Input channel (valid/stall): mode 0 starts a frame with command_code,
// status_code and payload_length; mode 1 carries one payload byte in
// data_byte. Output channel (valid/stall): one frame_byte per transaction,
// frame_end high on the high checksum byte that closes a frame.
// A start transaction yields eight header bytes (sync 0x49 0x37, sequence
// low/high, command, status, length low, zero), plus the two checksum bytes
// at once when the length is zero. A payload transaction yields its byte,
// plus the checksum when it is the last one. Payload with no frame open is
// taken and dropped.
// The first byte of a transaction is taken into the burst register on
// acceptance and then moves to the output register.
// Throughput: one transaction per cycle while each yields a single byte
// and the output is not stalled; a longer burst holds the emitter, the
// output register taking one byte a cycle unless stalled, so the input is
// stalled until the last byte of the burst moves to the output register.
// Output stall holds the output byte and backs up into input stall; the
// next transaction is still taken while the last byte of the current burst
// waits in the output register.
// Reset clears the sequence number, the checksum, the open-frame flag and
// empties the emitter; the first frame after reset carries sequence 1.
//

module command_frame_builder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] command_code,
  input  logic [7:0] status_code,
  input  logic [7:0] payload_length,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_end
);
  import cfb_pkg::*;

  logic [15:0] frame_sequence;
  logic [15:0] running_sum;
  logic [7:0]  bytes_remaining;
  logic        frame_open;

  logic [15:0] seq_next;
  logic [15:0] hdr_sum;
  logic [15:0] pay_sum;
  logic [7:0]  rem_next;
  logic        accept;
  logic        load;
  logic        free;
  burst_t      burst;

  assign in_stall = !free;
  assign accept   = in_valid && free;
  assign load     = accept && (!mode || frame_open);

  // header values and checksums
  assign seq_next = frame_sequence + 16'd1;
  assign hdr_sum  = 16'(SYNC_FIRST) + 16'(SYNC_SECOND) + 16'(seq_next[7:0])
                  + 16'(seq_next[15:8]) + 16'(command_code) + 16'(status_code)
                  + 16'(payload_length);
  assign pay_sum  = running_sum + 16'(data_byte);
  assign rem_next = bytes_remaining - 8'd1;

  // burst descriptor for the emitter
  always_comb begin
    burst.hdr  = !mode;
    burst.seq  = seq_next;
    burst.cmd  = command_code;
    burst.stat = status_code;
    burst.len  = payload_length;
    burst.data = data_byte;
    if (!mode) begin
      burst.with_sum = (payload_length == 8'd0);
      burst.sum      = hdr_sum;
    end else begin
      burst.with_sum = (rem_next == 8'd0);
      burst.sum      = pay_sum;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sequence  <= '0;
      running_sum     <= '0;
      bytes_remaining <= '0;
      frame_open      <= 1'b0;
    end else if (load) begin
      if (!mode) begin
        frame_sequence  <= seq_next;
        running_sum     <= hdr_sum;
        bytes_remaining <= payload_length;
        frame_open      <= (payload_length != 8'd0);
      end else begin
        running_sum     <= pay_sum;
        bytes_remaining <= rem_next;
        frame_open      <= (rem_next != 8'd0);
      end
    end
  end

  cfb_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst_in   (burst),
    .free       (free),
    .valid      (out_valid),
    .stall      (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

endmodule

FILE: dv/command_frame_builder_checker.sv
// command_frame_builder_checker: frame byte predictor and output comparison
`timescale 1ns / 1ps

module command_frame_builder_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       mode,
  input  logic [7:0] command_code,
  input  logic [7:0] status_code,
  input  logic [7:0] payload_length,
  input  logic [7:0] data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  output int         fail_count,
  output int         bytes_pending
);
  import cfb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_out_t;

  // shadow copy of the frame state
  logic [15:0] seq_num;
  logic [15:0] frame_sum;
  logic [7:0]  remaining;
  logic        frame_open;

  frame_out_t  expected_bytes[$];
  int          errors = 0;

  // queue a byte that counts towards the checksum
  task automatic push_summed(input logic [7:0] b);
    frame_sum = frame_sum + {8'h00, b};
    expected_bytes.push_back('{value: b, last: 1'b0});
  endtask

  // queue the two checksum bytes and close the frame
  task automatic push_checksum();
    expected_bytes.push_back('{value: frame_sum[7:0], last: 1'b0});
    expected_bytes.push_back('{value: frame_sum[15:8], last: 1'b1});
    frame_open = 1'b0;
    remaining  = '0;
  endtask

  // expected bytes caused by one accepted transaction
  task automatic predict_frame_bytes(input logic m, input logic [7:0] cmd,
                                     input logic [7:0] stat, input logic [7:0] len,
                                     input logic [7:0] data);
    if (m == MODE_START) begin
      seq_num   = seq_num + 16'd1;
      frame_sum = '0;
      push_summed(SYNC_FIRST);
      push_summed(SYNC_SECOND);
      push_summed(seq_num[7:0]);
      push_summed(seq_num[15:8]);
      push_summed(cmd);
      push_summed(stat);
      push_summed(len);
      push_summed(8'h00);
      remaining  = len;
      frame_open = 1'b1;
      if (len == 8'd0) push_checksum();
    end else if (m == MODE_PAYLOAD && frame_open) begin
      push_summed(data);
      remaining = remaining - 8'd1;
      if (remaining == 8'd0) push_checksum();
    end
  endtask

  // compare outgoing bytes, then predict from the incoming transaction
  always @(posedge clk) begin
    frame_out_t exp_byte;
    if (rst) begin
      seq_num    = '0;
      frame_sum  = '0;
      remaining  = '0;
      frame_open = 1'b0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected output, actual frame_byte %h frame_end %b",
                   $time, frame_byte, frame_end);
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (frame_byte !== exp_byte.value) begin
            errors++;
            $display("%0t: frame_byte mismatch, expected %h actual %h",
                     $time, exp_byte.value, frame_byte);
          end
          if (frame_end !== exp_byte.last) begin
            errors++;
            $display("%0t: frame_end mismatch, expected %b actual %b",
                     $time, exp_byte.last, frame_end);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_frame_bytes(mode, command_code, status_code, payload_length, data_byte);
    end
    bytes_pending <= expected_bytes.size();
    fail_count    <= errors;
  end

endmodule

FILE: dv/command_frame_builder_tb.sv
// command_frame_builder_tb: clock, reset, stimulus and verdict for the frame builder
`timescale 1ns / 1ps

module command_frame_builder_tb;
  import cfb_pkg::*;

  localparam int   ITEM_BUDGET  = 390;
  localparam int   CALM_FROM    = 340;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = 1'b0;
  logic [7:0] command_code = '0;
  logic [7:0] status_code = '0;
  logic [7:0] payload_length = '0;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_end;

  int          fail_count;
  int          bytes_pending;
  logic        quiet = 1'b0;
  int          stall_left = 0;
  int          rand_items = 0;

  command_frame_builder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .command_code   (command_code),
    .status_code    (status_code),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end)
  );

  command_frame_builder_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .command_code   (command_code),
    .status_code    (status_code),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .fail_count     (fail_count),
    .bytes_pending  (bytes_pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one transaction and hold it until taken, then maybe idle
  task automatic drive_item(input logic m, input logic [7:0] cmd, input logic [7:0] stat,
                            input logic [7:0] len, input logic [7:0] data);
    in_valid       <= 1'b1;
    mode           <= m;
    command_code   <= cmd;
    status_code    <= stat;
    payload_length <= len;
    data_byte      <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_start(input logic [7:0] cmd, input logic [7:0] stat,
                            input logic [7:0] len);
    drive_item(MODE_START, cmd, stat, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] data);
    drive_item(MODE_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom), data);
  endtask

  // random frames, mostly well formed
  task automatic random_frames();
    int   len;
    int   sent;
    int   cut;
    logic long_done;
    long_done = 1'b0;
    while (rand_items < ITEM_BUDGET) begin
      if (rand_items >= CALM_FROM) quiet <= 1'b1;
      if (!long_done && rand_items >= 40) begin
        // all-ones frame of full length: checksum wraps
        long_done = 1'b1;
        send_start(8'hFF, 8'hFF, 8'd255);
        for (int i = 0; i < 255; i++) send_payload(8'hFF);
        rand_items += 256;
      end else if ($urandom_range(0, 7) == 0) begin
        // frame abandoned part way by the next start
        len = $urandom_range(0, 255);
        cut = $urandom_range(0, 4);
        send_start(8'($urandom), 8'($urandom), 8'(len));
        rand_items++;
        for (sent = 0; sent < cut && sent < len - 1; sent++) begin
          send_payload(8'($urandom));
          rand_items++;
        end
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        send_start(8'($urandom), 8'($urandom), 8'(len));
        rand_items++;
        for (sent = 0; sent < len; sent++) begin
          send_payload(8'($urandom));
          rand_items++;
        end
        // stray payload after the frame has closed
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: dropped byte, empty frame, extremes, abandon, closed-frame drop
    send_payload(8'hFF);
    send_start(8'h00, 8'h00, 8'd0);
    send_start(8'hFF, 8'hFF, 8'd1);
    send_payload(8'hFF);
    send_start(8'hA5, 8'h5A, 8'd3);
    send_payload(8'h00);
    send_payload(8'h80);
    send_start(8'h3C, 8'hC3, 8'd2);
    send_payload(8'h7F);
    send_payload(8'h01);
    send_payload(8'h55);
    send_start(8'h12, 8'h34, 8'd255);
    send_payload(8'hFF);
    send_start(8'hFF, 8'h00, 8'd0);

    random_frames();
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
